/* src/arp_pkg.sv */
// ---------------------------------------------------------------------------
// arp_pkg: ARM relocation patcher shared definitions
// Relocation type codes, status codes, field masks and the bit-field
// helpers that build a patched instruction word.
// ---------------------------------------------------------------------------
package arp_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned CmdWidth    = 8;
   localparam int unsigned StatusWidth = 2;

   typedef logic [WordWidth-1:0]   word_type;
   typedef logic [CmdWidth-1:0]    cmd_type;
   typedef logic [StatusWidth-1:0] status_type;

   // ARM ELF relocation type numbers
   localparam cmd_type R_NONE            = 8'd0;
   localparam cmd_type R_ABS32           = 8'd2;
   localparam cmd_type R_REL32           = 8'd3;
   localparam cmd_type R_THM_CALL        = 8'd10;
   localparam cmd_type R_CALL            = 8'd28;
   localparam cmd_type R_JUMP24          = 8'd29;
   localparam cmd_type R_TARGET1         = 8'd38;
   localparam cmd_type R_V4BX            = 8'd40;
   localparam cmd_type R_TARGET2         = 8'd41;
   localparam cmd_type R_PREL31          = 8'd42;
   localparam cmd_type R_MOVW_ABS_NC     = 8'd43;
   localparam cmd_type R_MOVT_ABS        = 8'd44;
   localparam cmd_type R_THM_MOVW_ABS_NC = 8'd47;
   localparam cmd_type R_THM_MOVT_ABS    = 8'd48;

   // Result status codes
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_RANGE    = 2'd1;
   localparam status_type ST_SKIP     = 2'd2;
   localparam status_type ST_OVERFLOW = 2'd3;

   // Word masks
   localparam word_type V4BX_KEEP    = 32'hf000000f;
   localparam word_type V4BX_MOV_PC  = 32'h01a0f000;
   localparam word_type BR24_KEEP    = 32'hff000000;
   localparam word_type ARM_MOV_KEEP = 32'hfff0f000;
   localparam logic [15:0] THM_MOV_UP_KEEP = 16'hfbf0;
   localparam logic [15:0] THM_MOV_LO_KEEP = 16'h8f00;
   localparam logic [15:0] THM_BL_UP_KEEP  = 16'hf800;
   localparam logic [15:0] THM_BL_LO_KEEP  = 16'hd000;

   // Thumb BL / B.W: 25-bit offset into the halfword pair
   function automatic word_type thumb_bl(input word_type old, input word_type d);
      logic [15:0] up;
      logic [15:0] lo;
      logic        s;
      logic        j1;
      logic        j2;
      s  = d[24];
      j1 = s ^ ~d[23];
      j2 = s ^ ~d[22];
      up = (old[15:0] & THM_BL_UP_KEEP) | {5'd0, s, d[21:12]};
      lo = (old[31:16] & THM_BL_LO_KEEP) | {2'd0, j1, 1'b0, j2, d[11:1]};
      return {lo, up};
   endfunction

   // Thumb MOVW/MOVT: imm16 split as imm4:i:imm3:imm8
   function automatic word_type thumb_mov(input word_type old, input logic [15:0] imm);
      logic [15:0] up;
      logic [15:0] lo;
      up = (old[15:0] & THM_MOV_UP_KEEP) | {5'd0, imm[11], 6'd0, imm[15:12]};
      lo = (old[31:16] & THM_MOV_LO_KEEP) | {1'b0, imm[10:8], 4'd0, imm[7:0]};
      return {lo, up};
   endfunction

   // ARM MOVW/MOVT: imm4 at 19..16, imm12 at 11..0
   function automatic word_type arm_mov(input word_type old, input logic [15:0] imm);
      return (old & ARM_MOV_KEEP) | {12'd0, imm[15:12], 4'd0, imm[11:0]};
   endfunction

endpackage

/* src/arm_relocation_patcher_core.sv */
// ---------------------------------------------------------------------------
// arm_relocation_patcher_core: ARM ELF relocation patcher
// Takes one decoded relocation per item and returns the patched word,
// its write enable and a status.
// ---------------------------------------------------------------------------
// Each item is taken on a clock edge with start high (busy is always low, so
// one item may be issued every cycle). Its result is on the rsp_ ports with
// rsp_valid high for exactly one cycle, once the item has passed from the
// input register through the patch logic into the result register. The
// receiver cannot stall; results must be taken as they come. A result with
// write_enable low (skipped type, branch out of range or segment overflow)
// carries a zero patched word.
module arm_relocation_patcher_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  arp_pkg::cmd_type             req_cmd,
   input  arp_pkg::word_type            req_addend,
   input  arp_pkg::word_type            req_symbol_address,
   input  arp_pkg::word_type            req_place_address,
   input  arp_pkg::word_type            req_original_word,
   input  arp_pkg::word_type            req_offset_in_segment,
   input  arp_pkg::word_type            req_segment_size,
   output logic                         rsp_valid,
   output arp_pkg::word_type            rsp_patched_word,
   output logic                         rsp_write_enable,
   output arp_pkg::status_type          rsp_status
);

   // Input register
   logic               valid_ff;
   arp_pkg::cmd_type   cmd_ff;
   arp_pkg::word_type  addend_ff;
   arp_pkg::word_type  sym_ff;
   arp_pkg::word_type  place_ff;
   arp_pkg::word_type  old_ff;
   arp_pkg::word_type  off_ff;
   arp_pkg::word_type  size_ff;

   // Result register
   logic                 rsp_valid_ff;
   arp_pkg::word_type    word_ff;
   logic                 we_ff;
   arp_pkg::status_type  status_ff;

   arp_pkg::word_type    word_in;
   logic                 we_in;
   arp_pkg::status_type  status_in;

   arp_pkg::word_type    sa;
   arp_pkg::word_type    rel;
   arp_pkg::word_type    val;
   arp_pkg::status_type  st;
   logic                 br24_ok;
   logic                 thm_ok;
   logic [arp_pkg::WordWidth:0] end_pos;
   logic                 seg_over;

   assign busy = 1'b0;

   // Capture item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      if (start) begin
         cmd_ff    <= req_cmd;
         addend_ff <= req_addend;
         sym_ff    <= req_symbol_address;
         place_ff  <= req_place_address;
         old_ff    <= req_original_word;
         off_ff    <= req_offset_in_segment;
         size_ff   <= req_segment_size;
      end
   end

   // Address arithmetic and range checks
   always_comb begin
      sa  = sym_ff + addend_ff;
      rel = sa - place_ff;
      // signed rel in (-2^25, 2^25)
      br24_ok = (rel[31:25] == 7'h00) ||
                ((rel[31:25] == 7'h7f) && (rel != 32'hfe000000));
      // signed rel in (-2^24, 2^24)
      thm_ok  = (rel[31:24] == 8'h00) ||
                ((rel[31:24] == 8'hff) && (rel != 32'hff000000));
      end_pos  = {1'b0, off_ff} + 33'd4;
      seg_over = end_pos > {1'b0, size_ff};
   end

   // Patch by relocation type
   always_comb begin
      val = '0;
      st  = arp_pkg::ST_OK;
      case (cmd_ff)
         arp_pkg::R_ABS32, arp_pkg::R_TARGET1: begin
            val = sa;
         end
         arp_pkg::R_REL32, arp_pkg::R_TARGET2: begin
            val = rel;
         end
         arp_pkg::R_PREL31: begin
            val = {old_ff[31], rel[30:0]};
         end
         arp_pkg::R_V4BX: begin
            val = (old_ff & arp_pkg::V4BX_KEEP) | arp_pkg::V4BX_MOV_PC;
         end
         arp_pkg::R_CALL, arp_pkg::R_JUMP24: begin
            if (!br24_ok) begin
               st = arp_pkg::ST_RANGE;
            end else begin
               val = (old_ff & arp_pkg::BR24_KEEP) | {8'd0, rel[25:2]};
            end
         end
         arp_pkg::R_THM_CALL: begin
            if (!thm_ok) begin
               st = arp_pkg::ST_RANGE;
            end else begin
               val = arp_pkg::thumb_bl(old_ff, rel);
            end
         end
         arp_pkg::R_MOVW_ABS_NC: begin
            val = arp_pkg::arm_mov(old_ff, sa[15:0]);
         end
         arp_pkg::R_MOVT_ABS: begin
            val = arp_pkg::arm_mov(old_ff, sa[31:16]);
         end
         arp_pkg::R_THM_MOVW_ABS_NC: begin
            val = arp_pkg::thumb_mov(old_ff, sa[15:0]);
         end
         arp_pkg::R_THM_MOVT_ABS: begin
            val = arp_pkg::thumb_mov(old_ff, sa[31:16]);
         end
         default: begin
            st = arp_pkg::ST_SKIP;
         end
      endcase
      // overflow ranks below skip and range
      if ((st == arp_pkg::ST_OK) && seg_over) begin
         st = arp_pkg::ST_OVERFLOW;
      end
      status_in = st;
      we_in     = (st == arp_pkg::ST_OK);
      word_in   = we_in ? val : '0;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
      if (valid_ff) begin
         word_ff   <= word_in;
         we_ff     <= we_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_patched_word = word_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_status       = status_ff;

   // Checks
   a_pipe_in: assert property (@(posedge clock) disable iff (reset)
      start |=> valid_ff)
      else $error("accepted item not captured");

   a_pipe_out: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> rsp_valid_ff)
      else $error("captured item produced no result");

   a_we_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_enable == (rsp_status == arp_pkg::ST_OK)))
      else $error("write enable disagrees with status");

   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_patched_word == '0))
      else $error("refused write carries nonzero word");

endmodule

/* verif/arm_relocation_patcher_core_tb.sv */
// ---------------------------------------------------------------------------
// arm_relocation_patcher_core_tb: self-checking bench for the relocation patcher
// Drives decoded ARM relocations through the start/busy port and predicts
// the patched word, write enable and status of every accepted item. A
// scoreboard compares each strobed result against the oldest prediction.
// The run covers a directed pass over every type code, branch range edges
// and segment fit edges, then a long random pass with random gaps.
// ---------------------------------------------------------------------------
module arm_relocation_patcher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam arp_pkg::cmd_type KNOWN_CMDS [14] = '{
      arp_pkg::R_NONE, arp_pkg::R_ABS32, arp_pkg::R_REL32, arp_pkg::R_THM_CALL,
      arp_pkg::R_CALL, arp_pkg::R_JUMP24, arp_pkg::R_TARGET1, arp_pkg::R_V4BX,
      arp_pkg::R_TARGET2, arp_pkg::R_PREL31, arp_pkg::R_MOVW_ABS_NC,
      arp_pkg::R_MOVT_ABS, arp_pkg::R_THM_MOVW_ABS_NC, arp_pkg::R_THM_MOVT_ABS
   };

   typedef struct packed {
      arp_pkg::cmd_type  cmd;
      arp_pkg::word_type addend;
      arp_pkg::word_type symbol_address;
      arp_pkg::word_type place_address;
      arp_pkg::word_type original_word;
      arp_pkg::word_type offset_in_segment;
      arp_pkg::word_type segment_size;
   } relocation_type;

   typedef struct packed {
      arp_pkg::word_type   patched_word;
      logic                write_enable;
      arp_pkg::status_type status;
   } patch_type;

   // Holds predicted patches in issue order and checks strobed results
   class patch_scoreboard;
      patch_type   expected_patches[$];
      int unsigned mismatches = 0;

      function int unsigned pending();
         return expected_patches.size();
      endfunction

      // Patched word and status for one relocation
      function patch_type predict_patch(relocation_type r);
         arp_pkg::word_type   target;
         arp_pkg::word_type   delta;
         arp_pkg::word_type   word;
         logic [15:0]         imm;
         arp_pkg::status_type st;
         int                  sdelta;
         logic [32:0]         seg_end;
         patch_type           p;
         target = r.symbol_address + r.addend;
         delta  = target - r.place_address;
         sdelta = $signed(delta);
         word   = '0;
         st     = arp_pkg::ST_OK;
         imm    = (r.cmd == arp_pkg::R_MOVT_ABS || r.cmd == arp_pkg::R_THM_MOVT_ABS) ?
                  target[31:16] : target[15:0];
         case (r.cmd)
            arp_pkg::R_ABS32, arp_pkg::R_TARGET1: begin
               word = target;
            end
            arp_pkg::R_REL32, arp_pkg::R_TARGET2: begin
               word = delta;
            end
            arp_pkg::R_PREL31: begin
               word = {r.original_word[31], delta[30:0]};
            end
            arp_pkg::R_V4BX: begin
               // keep cond and Rm, force MOV PC,Rm
               word = {r.original_word[31:28], 24'h1a0f00, r.original_word[3:0]};
            end
            arp_pkg::R_CALL, arp_pkg::R_JUMP24: begin
               if (sdelta <= -33554432 || sdelta >= 33554432) begin
                  st = arp_pkg::ST_RANGE;
               end else begin
                  word = {r.original_word[31:24], delta[25:2]};
               end
            end
            arp_pkg::R_THM_CALL: begin
               if (sdelta <= -16777216 || sdelta >= 16777216) begin
                  st = arp_pkg::ST_RANGE;
               end else begin
                  // second halfword in 31..16: J1, J2, imm11; first: S, imm10
                  word = {r.original_word[31:30], ~(delta[24] ^ delta[23]),
                          r.original_word[28], ~(delta[24] ^ delta[22]),
                          delta[11:1], r.original_word[15:11], delta[24],
                          delta[21:12]};
               end
            end
            arp_pkg::R_MOVW_ABS_NC, arp_pkg::R_MOVT_ABS: begin
               word = {r.original_word[31:20], imm[15:12],
                       r.original_word[15:12], imm[11:0]};
            end
            arp_pkg::R_THM_MOVW_ABS_NC, arp_pkg::R_THM_MOVT_ABS: begin
               // imm3:imm8 in second halfword, i:imm4 in first
               word = {r.original_word[31], imm[10:8], r.original_word[27:24],
                       imm[7:0], r.original_word[15:11], imm[11],
                       r.original_word[9:4], imm[15:12]};
            end
            default: begin
               st = arp_pkg::ST_SKIP;
            end
         endcase
         // store of 4 bytes must fit, no wrap
         seg_end = {1'b0, r.offset_in_segment} + 33'd4;
         if (st == arp_pkg::ST_OK && seg_end > {1'b0, r.segment_size})
            st = arp_pkg::ST_OVERFLOW;
         if (st != arp_pkg::ST_OK) word = '0;
         p.patched_word = word;
         p.write_enable = (st == arp_pkg::ST_OK);
         p.status       = st;
         return p;
      endfunction

      function void note_relocation(relocation_type r);
         expected_patches.push_back(predict_patch(r));
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH %s", $realtime, what);
         mismatches++;
      endtask

      task check_patch(patch_type got);
         patch_type want;
         if (expected_patches.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: word %08h we %0b st %0d",
                                      got.patched_word, got.write_enable, got.status));
         end else begin
            want = expected_patches.pop_front();
            if (got.patched_word !== want.patched_word)
               report_mismatch($sformatf("patched_word %08h, want %08h",
                                         got.patched_word, want.patched_word));
            if (got.write_enable !== want.write_enable)
               report_mismatch($sformatf("write_enable %0b, want %0b",
                                         got.write_enable, want.write_enable));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   arp_pkg::cmd_type    req_cmd = '0;
   arp_pkg::word_type   req_addend = '0;
   arp_pkg::word_type   req_symbol_address = '0;
   arp_pkg::word_type   req_place_address = '0;
   arp_pkg::word_type   req_original_word = '0;
   arp_pkg::word_type   req_offset_in_segment = '0;
   arp_pkg::word_type   req_segment_size = '0;
   logic                rsp_valid;
   arp_pkg::word_type   rsp_patched_word;
   logic                rsp_write_enable;
   arp_pkg::status_type rsp_status;

   int unsigned     cycle_count = 0;
   patch_scoreboard scoreboard = new();

   arm_relocation_patcher_core DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_addend            (req_addend),
      .req_symbol_address    (req_symbol_address),
      .req_place_address     (req_place_address),
      .req_original_word     (req_original_word),
      .req_offset_in_segment (req_offset_in_segment),
      .req_segment_size      (req_segment_size),
      .rsp_valid             (rsp_valid),
      .rsp_patched_word      (rsp_patched_word),
      .rsp_write_enable      (rsp_write_enable),
      .rsp_status            (rsp_status)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("arm_relocation_patcher_core_tb: FAIL");
         $finish;
      end
   end

   // Monitor: note accepted items, check strobed results (pre-edge values)
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            scoreboard.note_relocation('{cmd: req_cmd, addend: req_addend,
                                         symbol_address: req_symbol_address,
                                         place_address: req_place_address,
                                         original_word: req_original_word,
                                         offset_in_segment: req_offset_in_segment,
                                         segment_size: req_segment_size});
         if (rsp_valid)
            scoreboard.check_patch('{patched_word: rsp_patched_word,
                                     write_enable: rsp_write_enable,
                                     status: rsp_status});
      end
   end

   // Present one item at the falling edge and hold it until accepted
   task automatic drive_relocation(input relocation_type r);
      @(negedge clock);
      start                 <= 1'b1;
      req_cmd               <= r.cmd;
      req_addend            <= r.addend;
      req_symbol_address    <= r.symbol_address;
      req_place_address     <= r.place_address;
      req_original_word     <= r.original_word;
      req_offset_in_segment <= r.offset_in_segment;
      req_segment_size      <= r.segment_size;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Random idle gap: mostly none, some short, a few long
   task automatic idle_gap();
      int unsigned pick;
      int unsigned gap;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stop issuing and wait for every pending result
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   task automatic send_relocation(input arp_pkg::cmd_type cmd,
                                  input arp_pkg::word_type addend,
                                  input arp_pkg::word_type sym,
                                  input arp_pkg::word_type place,
                                  input arp_pkg::word_type original,
                                  input arp_pkg::word_type offset,
                                  input arp_pkg::word_type seg_size);
      relocation_type r;
      r = '{cmd: cmd, addend: addend, symbol_address: sym, place_address: place,
            original_word: original, offset_in_segment: offset, segment_size: seg_size};
      drive_relocation(r);
      idle_gap();
   endtask

   // Branch with a chosen S+A-P over random S and P
   task automatic send_branch(input arp_pkg::cmd_type cmd, input arp_pkg::word_type delta,
                              input arp_pkg::word_type original,
                              input arp_pkg::word_type offset,
                              input arp_pkg::word_type seg_size);
      arp_pkg::word_type sym;
      arp_pkg::word_type place;
      sym   = $urandom;
      place = $urandom;
      send_relocation(cmd, delta - sym + place, sym, place, original, offset, seg_size);
   endtask

   function automatic relocation_type random_relocation();
      relocation_type    r;
      arp_pkg::word_type w;
      arp_pkg::word_type delta;
      arp_pkg::word_type limit;
      r.cmd = ($urandom_range(0, 99) < 80) ? KNOWN_CMDS[$urandom_range(0, 13)]
                                           : arp_pkg::cmd_type'($urandom_range(0, 255));
      r.symbol_address = ($urandom_range(0, 7) == 0) ? '0 : arp_pkg::word_type'($urandom);
      r.place_address  = $urandom;
      r.original_word  = $urandom;
      r.addend         = $urandom;
      if (r.cmd == arp_pkg::R_CALL || r.cmd == arp_pkg::R_JUMP24 ||
          r.cmd == arp_pkg::R_THM_CALL) begin
         w     = $urandom;
         limit = (r.cmd == arp_pkg::R_THM_CALL) ? 32'h0100_0000 : 32'h0200_0000;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // mostly in range
               delta = (r.cmd == arp_pkg::R_THM_CALL) ? {{7{w[24]}}, w[24:0]}
                                                      : {{6{w[25]}}, w[25:0]};
            end
            6, 7: begin
               // around either range edge
               delta = (w[31] ? limit : -limit) + $urandom_range(0, 6) - 3;
            end
            default: begin
               delta = w;
            end
         endcase
         r.addend = delta - r.symbol_address + r.place_address;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6, 7: begin
            r.segment_size      = $urandom;
            r.offset_in_segment = (r.segment_size >= 4) ?
                                  $urandom_range(0, r.segment_size - 4) :
                                  $urandom_range(0, 3);
         end
         8: begin
            // around the exact fit
            r.segment_size      = $urandom;
            r.offset_in_segment = r.segment_size - 4 + $urandom_range(0, 7);
         end
         default: begin
            r.segment_size      = $urandom;
            r.offset_in_segment = $urandom;
         end
      endcase
      return r;
   endfunction

   initial begin
      relocation_type r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every type, branch range edges, segment fit edges
      send_relocation(arp_pkg::R_ABS32, '1, '1, '0, '0, '0, 32'd4);
      send_relocation(arp_pkg::R_TARGET1, '0, '0, '1, '1, 32'hffff_fffb, '1);
      send_relocation(arp_pkg::R_REL32, $urandom, $urandom, $urandom, $urandom,
                      32'd16, 32'd64);
      send_relocation(arp_pkg::R_TARGET2, $urandom, '0, '1, $urandom, '0, '1);
      send_relocation(arp_pkg::R_PREL31, $urandom, $urandom, $urandom, '1, '0, 32'd8);
      send_relocation(arp_pkg::R_PREL31, $urandom, $urandom, $urandom, '0, '0, 32'd8);
      send_relocation(arp_pkg::R_V4BX, $urandom, $urandom, $urandom, '1, '0, 32'd4);
      send_relocation(arp_pkg::R_V4BX, $urandom, $urandom, $urandom, '0, '0, 32'd4);
      send_branch(arp_pkg::R_CALL, 32'h01ff_ffff, $urandom, '0, 32'd4);
      send_branch(arp_pkg::R_CALL, 32'h0200_0000, $urandom, '0, 32'd4);
      send_branch(arp_pkg::R_JUMP24, -32'h01ff_ffff, '1, '0, 32'd4);
      send_branch(arp_pkg::R_JUMP24, -32'h0200_0000, $urandom, '0, 32'd4);
      send_branch(arp_pkg::R_THM_CALL, 32'h00ff_ffff, '0, '0, 32'd4);
      send_branch(arp_pkg::R_THM_CALL, 32'h0100_0000, $urandom, '0, 32'd4);
      send_branch(arp_pkg::R_THM_CALL, -32'h00ff_ffff, '1, '0, 32'd4);
      send_branch(arp_pkg::R_THM_CALL, -32'h0100_0000, $urandom, '0, 32'd4);
      send_relocation(arp_pkg::R_MOVW_ABS_NC, '1, '0, $urandom, '0, '0, 32'd4);
      send_relocation(arp_pkg::R_MOVT_ABS, '0, '1, $urandom, '1, '0, 32'd4);
      send_relocation(arp_pkg::R_THM_MOVW_ABS_NC, '1, '0, $urandom, '0, '0, 32'd4);
      send_relocation(arp_pkg::R_THM_MOVT_ABS, '0, '0, $urandom, '1, '0, 32'd4);
      send_relocation(arp_pkg::R_NONE, $urandom, $urandom, $urandom, $urandom, '0, 32'd4);
      // skipped type wins over overflow
      send_relocation(8'd255, $urandom, $urandom, $urandom, $urandom, '1, '0);
      // range failure wins over overflow
      send_branch(arp_pkg::R_CALL, 32'h4000_0000, $urandom, '1, '0);
      send_relocation(arp_pkg::R_ABS32, $urandom, $urandom, $urandom, $urandom,
                      32'd61, 32'd64);
      send_relocation(arp_pkg::R_ABS32, $urandom, $urandom, $urandom, $urandom, '1, '1);
      send_relocation(arp_pkg::R_ABS32, $urandom, $urandom, $urandom, $urandom, '0, '0);

      // Random part, with some back-to-back stretches
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         r = random_relocation();
         drive_relocation(r);
         if (i == RANDOM_ITEMS / 2) drain_results();
         else if ((i / 40) % 4 != 1) idle_gap();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0) begin
         $display("arm_relocation_patcher_core_tb: PASS");
      end else begin
         $display("arm_relocation_patcher_core_tb: FAIL");
      end
      $finish;
   end

endmodule
